>>> design/psyn_pkg.sv
// Shared types, constants and helper functions for the polyphonic sine synthesizer.
package psyn_pkg;

    localparam int VOICES_DEF          = 8;
    localparam int SINE_INDEX_BITS_DEF = 10;
    localparam int SAMPLE_RATE         = 44100;

    localparam int AMP_W    = 24;
    localparam int PHASE_W  = 32;
    localparam int INCR_W   = 32;
    localparam int SINE_W   = 16;
    localparam int X_W      = 16;
    localparam int COEF_W   = 25;
    localparam int PROD_W   = AMP_W + SINE_W + 1;
    localparam int SAMPLE_W = 19;
    localparam int COUNT_W  = 4;
    localparam int PITCH_W  = 4;
    localparam int OCTAVE_W = 4;
    localparam int PITCHES  = 12;

    localparam logic [AMP_W-1:0] AMP_FULL = 24'hFFFFFF;
    localparam logic [AMP_W-1:0] FADE_STEP_RESET = 24'd380;

    localparam logic [COEF_W-1:0] COEF_C1 = 25'd26353589;
    localparam logic [COEF_W-1:0] COEF_C3 = 25'd10837479;
    localparam logic [COEF_W-1:0] COEF_C5 = 25'd1337020;
    localparam logic [COEF_W-1:0] COEF_C7 = 25'd78548;

    localparam logic signed [31:0] SAMPLE_MAX = 32'sd262143;
    localparam logic signed [31:0] SAMPLE_MIN = -32'sd262144;

    localparam longint unsigned INC_DEN  = 64'd100 * 64'(SAMPLE_RATE);
    localparam longint unsigned INC_HALF = INC_DEN / 2;

    localparam logic [INCR_W-1:0] INC4_TABLE [PITCHES] = '{
        32'(((64'd26163 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd27718 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd29366 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd31113 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd32963 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd34923 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd36999 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd39200 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd41530 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd44000 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd46616 << 32) + INC_HALF) / INC_DEN),
        32'(((64'd49388 << 32) + INC_HALF) / INC_DEN)
    };

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_NOTE_ON = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_NOP     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_DROPPED   = 2'd1,
        STATUS_BAD_PITCH = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [INCR_W-1:0]  incr;
        logic [PHASE_W-1:0] phase;
        logic [AMP_W-1:0]   amp;
    } voice_word_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               act;
        logic [AMP_W-1:0]   amp;
        logic [PHASE_W-1:0] phase;
    } sine_in_t;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [PROD_W-1:0] prod;
    } sine_out_t;

    function automatic logic [INCR_W-1:0] note_incr(
        input logic [PITCH_W-1:0]  pitch,
        input logic [OCTAVE_W-1:0] octave
    );
        logic [INCR_W-1:0]   base;
        logic [OCTAVE_W-1:0] oct;
        logic [INCR_W-1:0]   result;
        base = (pitch < PITCH_W'(PITCHES)) ? INC4_TABLE[pitch] : '0;
        oct  = (octave > 4'd8) ? 4'd8 : octave;
        if (oct >= 4'd4) begin
            result = base << (oct - 4'd4);
        end else begin
            result = base >> (4'd4 - oct);
        end
        return result;
    endfunction

endpackage

>>> design/psyn_voice_mem.sv
// Voice state memory: one write port, one registered read port.
module psyn_voice_mem
    import psyn_pkg::*;
#(
    parameter int DEPTH  = VOICES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  voice_word_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output voice_word_t       rd_data
);

    voice_word_t voice_mem [DEPTH];
    voice_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            voice_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= voice_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/psyn_sine_pipe.sv
// Seven-stage sine evaluation and amplitude product pipeline, one voice per cycle.
module psyn_sine_pipe
    import psyn_pkg::*;
#(
    parameter int SINE_INDEX_BITS = SINE_INDEX_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  sine_in_t  sin_i,
    output sine_out_t sout_o
);

    localparam int QBITS  = SINE_INDEX_BITS - 2;
    localparam int XSHIFT = 15 - QBITS;

    logic [SINE_INDEX_BITS-1:0] idx;
    logic [X_W-1:0]             xq;
    logic [X_W-1:0]             x_in;

    logic [6:0] valid_reg;
    logic [6:0] last_reg;

    logic             s1_act_reg, s2_act_reg, s3_act_reg, s4_act_reg, s5_act_reg, s6_act_reg;
    logic             s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg, s5_neg_reg;
    logic [AMP_W-1:0] s1_amp_reg, s2_amp_reg, s3_amp_reg, s4_amp_reg, s5_amp_reg, s6_amp_reg;
    logic [X_W-1:0]   s1_x_reg, s2_x_reg, s3_x_reg, s4_x_reg, s5_x_reg;
    logic [X_W-1:0]   s2_x2_reg, s3_x2_reg, s4_x2_reg;
    logic [COEF_W-1:0] s3_t_reg, s4_t_reg, s5_t_reg;
    logic signed [SINE_W-1:0] s6_sine_reg;
    logic signed [PROD_W-1:0] s7_prod_reg;

    logic [31:0]            x_sq;
    logic [40:0]            t3_prod, t4_prod, t5_prod, m_prod;
    logic [16:0]            mag_wide;
    logic [14:0]            mag;
    logic signed [SINE_W-1:0] sine_mag;

    always_comb begin
        idx      = sin_i.phase[PHASE_W-1 -: SINE_INDEX_BITS];
        xq       = X_W'(idx[QBITS-1:0]) << XSHIFT;
        x_in     = idx[SINE_INDEX_BITS-2] ? (16'd32768 - xq) : xq;
        x_sq     = 32'(s1_x_reg) * 32'(s1_x_reg);
        t3_prod  = 41'(COEF_C7) * 41'(s2_x2_reg);
        t4_prod  = 41'(s3_t_reg) * 41'(s3_x2_reg);
        t5_prod  = 41'(s4_t_reg) * 41'(s4_x2_reg);
        m_prod   = 41'(s5_t_reg) * 41'(s5_x_reg) + 41'(24'h800000);
        mag_wide = 17'(m_prod >> 24);
        mag      = (mag_wide > 17'd32767) ? 15'h7FFF : 15'(mag_wide);
        sine_mag = signed'({1'b0, mag});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[5:0], sin_i.valid};
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= {last_reg[5:0], sin_i.last};

        s1_act_reg <= sin_i.act;
        s1_neg_reg <= idx[SINE_INDEX_BITS-1];
        s1_amp_reg <= sin_i.amp;
        s1_x_reg   <= x_in;

        s2_act_reg <= s1_act_reg;
        s2_neg_reg <= s1_neg_reg;
        s2_amp_reg <= s1_amp_reg;
        s2_x_reg   <= s1_x_reg;
        s2_x2_reg  <= X_W'(x_sq >> 15);

        s3_act_reg <= s2_act_reg;
        s3_neg_reg <= s2_neg_reg;
        s3_amp_reg <= s2_amp_reg;
        s3_x_reg   <= s2_x_reg;
        s3_x2_reg  <= s2_x2_reg;
        s3_t_reg   <= COEF_C5 - COEF_W'(t3_prod >> 15);

        s4_act_reg <= s3_act_reg;
        s4_neg_reg <= s3_neg_reg;
        s4_amp_reg <= s3_amp_reg;
        s4_x_reg   <= s3_x_reg;
        s4_x2_reg  <= s3_x2_reg;
        s4_t_reg   <= COEF_C3 - COEF_W'(t4_prod >> 15);

        s5_act_reg <= s4_act_reg;
        s5_neg_reg <= s4_neg_reg;
        s5_amp_reg <= s4_amp_reg;
        s5_x_reg   <= s4_x_reg;
        s5_t_reg   <= COEF_C1 - COEF_W'(t5_prod >> 15);

        s6_act_reg  <= s5_act_reg;
        s6_amp_reg  <= s5_amp_reg;
        s6_sine_reg <= s5_neg_reg ? -sine_mag : sine_mag;

        s7_prod_reg <= s6_act_reg ? (signed'({1'b0, s6_amp_reg}) * s6_sine_reg)
                                  : signed'(PROD_W'(0));
    end

    assign sout_o.valid = valid_reg[6];
    assign sout_o.last  = last_reg[6];
    assign sout_o.prod  = s7_prod_reg;

endmodule

>>> design/polyphonic_sine_synth.sv
// Tick: the next input is taken only once the result is in the output register.
// The tick time is set by the voice memory's single read port, one voice per cycle,
// followed by the seven-stage sine and product pipeline and the accumulator.
// Note on, release and no operation: the result goes out through the finish state likewise.
// Reset (aresetn low, synchronous) frees all voices, empties the output, fade_step = 380.
// Top level of the polyphonic sine synthesizer.
module polyphonic_sine_synth
    import psyn_pkg::*;
#(
    parameter int VOICES          = VOICES_DEF,
    parameter int SINE_INDEX_BITS = SINE_INDEX_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] pitch_class, [7:4] octave
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [18:0] sample, [22:19] voice_count, [23] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata
);

    localparam int ADDR_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W  = $clog2(VOICES + 1);
    localparam int ACC_W  = PROD_W + $clog2(VOICES) + 1;
    localparam int SHR_W  = ACC_W - 24;

    state_t                   state_reg, state_next;
    logic [AMP_W-1:0]         fade_step_reg;
    logic [VOICES-1:0]        active_reg, active_next;
    logic [VOICES-1:0]        fading_reg, fading_next;
    logic [CNT_W-1:0]         issue_cnt_reg, issue_cnt_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic                     rd_last_reg, rd_last_next;
    logic [ADDR_W-1:0]        rd_idx_reg, rd_idx_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [SAMPLE_W-1:0]      res_sample_reg, res_sample_next;
    status_t                  res_status_reg, res_status_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]      m_sample_reg, m_sample_next;
    status_t                  m_status_reg, m_status_next;
    logic [COUNT_W-1:0]       m_count_reg, m_count_next;

    logic                     mem_we, mem_re;
    logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
    voice_word_t              mem_wdata, mem_rdata;
    sine_in_t                 sin;
    sine_out_t                sout;

    logic                     in_xfer;
    kind_t                    in_kind;
    logic [PITCH_W-1:0]       in_pitch;
    logic [OCTAVE_W-1:0]      in_octave;
    logic                     free_found;
    logic [ADDR_W-1:0]        free_idx;
    logic                     wb_act, wb_fad;
    logic [AMP_W-1:0]         wb_amp;
    logic [PHASE_W-1:0]       wb_phase;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [SHR_W-1:0]  acc_shr;
    logic signed [31:0]       acc_wide;
    logic [CNT_W-1:0]         active_cnt;

    psyn_voice_mem #(
        .DEPTH  (VOICES),
        .ADDR_W (ADDR_W)
    ) u_voice_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    psyn_sine_pipe #(
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_sine_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sin_i   (sin),
        .sout_o  (sout)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fade_step_reg <= FADE_STEP_RESET;
            active_reg    <= '0;
            fading_reg    <= '0;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            fading_reg    <= fading_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we) begin
                fade_step_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_last_reg    <= rd_last_next;
        rd_idx_reg     <= rd_idx_next;
        acc_reg        <= acc_next;
        res_sample_reg <= res_sample_next;
        res_status_reg <= res_status_next;
        m_sample_reg   <= m_sample_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

    always_comb begin
        in_kind   = kind_t'(s_tuser);
        in_pitch  = s_tdata[3:0];
        in_octave = s_tdata[7:4];
        in_xfer   = s_tvalid && (state_reg == ST_IDLE);

        free_found = 1'b0;
        free_idx   = '0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!active_reg[v]) begin
                free_found = 1'b1;
                free_idx   = ADDR_W'(v);
            end
        end

        active_cnt = '0;
        for (int v = 0; v < VOICES; v++) begin
            active_cnt = active_cnt + CNT_W'(active_reg[v]);
        end

        wb_act   = active_reg[rd_idx_reg];
        wb_fad   = fading_reg[rd_idx_reg];
        wb_amp   = mem_rdata.amp;
        if (wb_fad) begin
            wb_amp = (mem_rdata.amp > fade_step_reg) ? (mem_rdata.amp - fade_step_reg) : '0;
        end
        wb_phase = mem_rdata.phase + mem_rdata.incr;

        acc_sum  = acc_reg + ACC_W'(sout.prod);
        acc_shr  = SHR_W'(acc_sum >>> 24);
        acc_wide = 32'(acc_shr);

        sin.valid = rd_valid_reg;
        sin.last  = rd_last_reg;
        sin.act   = wb_act;
        sin.amp   = mem_rdata.amp;
        sin.phase = mem_rdata.phase;
    end

    always_comb begin
        state_next      = state_reg;
        active_next     = active_reg;
        fading_next     = fading_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_valid_next   = 1'b0;
        rd_last_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        acc_next        = acc_reg;
        res_sample_next = res_sample_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_sample_next   = m_sample_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;
        mem_wdata       = '{incr: note_incr(in_pitch, in_octave), phase: '0, amp: AMP_FULL};
        mem_re          = 1'b0;
        mem_raddr       = issue_cnt_reg[ADDR_W-1:0];
        s_tready        = (state_reg == ST_IDLE);

        // write back each active voice, one per cycle, while a tick walks the memory
        if (rd_valid_reg && wb_act) begin
            mem_we          = 1'b1;
            mem_waddr       = rd_idx_reg;
            mem_wdata.incr  = mem_rdata.incr;
            mem_wdata.amp   = wb_amp;
            mem_wdata.phase = (wb_amp == '0) ? '0 : wb_phase;
            if (wb_amp == '0) begin
                active_next[rd_idx_reg] = 1'b0;
                fading_next[rd_idx_reg] = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    res_sample_next = '0;
                    res_status_next = STATUS_OK;
                    state_next      = ST_FINISH;
                    case (in_kind)
                        KIND_TICK: begin
                            issue_cnt_next = '0;
                            acc_next       = '0;
                            state_next     = ST_TICK;
                        end
                        KIND_NOTE_ON: begin
                            if (in_pitch >= PITCH_W'(PITCHES)) begin
                                res_status_next = STATUS_BAD_PITCH;
                            end else if (!free_found) begin
                                res_status_next = STATUS_DROPPED;
                            end else begin
                                mem_we                = 1'b1;
                                active_next[free_idx] = 1'b1;
                                fading_next[free_idx] = 1'b0;
                            end
                        end
                        KIND_RELEASE: begin
                            fading_next = fading_reg | active_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (issue_cnt_reg < CNT_W'(VOICES)) begin
                    mem_re         = 1'b1;
                    rd_valid_next  = 1'b1;
                    rd_last_next   = (issue_cnt_reg == CNT_W'(VOICES - 1));
                    rd_idx_next    = issue_cnt_reg[ADDR_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (sout.valid) begin
                    acc_next = acc_sum;
                    if (sout.last) begin
                        if (acc_wide > SAMPLE_MAX) begin
                            res_sample_next = SAMPLE_W'(SAMPLE_MAX);
                        end else if (acc_wide < SAMPLE_MIN) begin
                            res_sample_next = SAMPLE_W'(SAMPLE_MIN);
                        end else begin
                            res_sample_next = SAMPLE_W'(acc_wide);
                        end
                        res_status_next = STATUS_OK;
                        state_next      = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_sample_next = res_sample_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = COUNT_W'(active_cnt);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_sample_reg};
    assign m_tuser  = m_status_reg;

endmodule

>>> design/psyn_checker.sv
// Port-level checker for the polyphonic sine synthesizer, bound to the top level.
module psyn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_reset_empties_output: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("output valid after reset");

    a_one_item_in_flight: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input taken while an item is still in work");

    a_stalled_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    ) else $error("stalled result changed");

    a_flagged_note_is_silent: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != 2'd0) |-> (m_tdata[18:0] == 19'd0 && m_tuser != 2'd3)
    ) else $error("flagged result carries a sample or an unknown status");

endmodule

bind polyphonic_sine_synth psyn_checker u_psyn_checker (.*);
